@@ design/mss_pkg.sv @@
// shared types and constants for the merge sort stage
package mss_pkg;

    // fixed widths of the stream fields
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 2 * VALUE_W;
    localparam int M_TDATA_W = VALUE_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_a_in;     // item accepted: store value_a, hold value_b
        logic wr_b_in;     // store held value_b, advance load count
        logic batch_init;  // set first run width, source buffer, emit index
        logic seg_init;    // set merge pointers for the pair of runs at left
        logic merge_wr;    // write smaller head to destination, advance
        logic seg_next;    // move left to the next pair of runs
        logic pass_next;   // double run width, swap buffers
        logic emit_rd;     // read the emit index from the final buffer
        logic emit_ld;     // load output register, copy back, advance index
    } t_mss_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic load_last;   // current item completes the batch
        logic run_done;    // both runs of the current pair consumed
        logic seg_last;    // current pair is the last one of the pass
        logic merge_done;  // run width covers the whole buffer
        logic emit_last;   // emit index points at the final element
        logic out_free;    // output register can take a value this cycle
    } t_mss_status;

endpackage

@@ design/mss_ctrl.sv @@
// controller state machine: load, merge passes, emit
module mss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  mss_pkg::t_mss_status i_status,
    output mss_pkg::t_mss_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_LOAD_B,
        S_PASS,
        S_SEG,
        S_RD,
        S_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_LOAD);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    o_cmd.wr_a_in = 1'b1;
                    n_state       = S_LOAD_B;
                end
            end
            S_LOAD_B: begin
                o_cmd.wr_b_in = 1'b1;
                if (i_status.load_last) begin
                    o_cmd.batch_init = 1'b1;
                    n_state          = S_PASS;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_PASS: begin
                n_state = i_status.merge_done ? S_EMIT_RD : S_SEG;
            end
            S_SEG: begin
                o_cmd.seg_init = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                if (i_status.run_done) begin
                    if (i_status.seg_last) begin
                        o_cmd.pass_next = 1'b1;
                        n_state         = S_PASS;
                    end else begin
                        o_cmd.seg_next = 1'b1;
                        n_state        = S_SEG;
                    end
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.merge_wr = 1'b1;
                n_state        = S_RD;
            end
            S_EMIT_RD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_cmd.emit_ld = 1'b1;
                n_state       = i_status.emit_last ? S_LOAD : S_EMIT_RD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/mss_datapath.sv @@
// datapath: two buffers, merge pointers, comparator and output register
module mss_datapath #(
    parameter int RUN_LENGTH = 8,
    parameter int TOTAL      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mss_pkg::t_mss_cmd               i_cmd,
    output mss_pkg::t_mss_status            o_status,
    input  logic [mss_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mss_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int AW = $clog2(TOTAL);
    localparam int PW = $clog2(3 * TOTAL + 2 * RUN_LENGTH + 1);
    localparam int CW = $clog2(RUN_LENGTH + 1);
    localparam int VW = mss_pkg::VALUE_W;

    // buffers: a holds the loaded and final data, b is the ping-pong partner
    logic [DATA_WIDTH-1:0] mem_a [TOTAL];
    logic [DATA_WIDTH-1:0] mem_b [TOTAL];

    logic [DATA_WIDTH-1:0] r_rd_a0, r_rd_a1, r_rd_b0, r_rd_b1;
    logic [DATA_WIDTH-1:0] r_in_b;
    logic [CW-1:0]         r_cnt;
    logic [PW-1:0]         r_i, r_j, r_m, r_left, r_mid, r_end, r_width, r_k;
    logic                  r_src;
    logic                  r_out_valid;
    logic [VW-1:0]         r_out_value;
    logic                  r_out_last;

    logic [DATA_WIDTH+VW-1:0] ext_a, ext_b;
    logic [DATA_WIDTH-1:0]    in_a_w, in_b_w;
    logic [PW-1:0]            pos_a, pos_b, two_w, left_far, left_near;
    logic [AW-1:0]            addr0, addr1;
    logic [DATA_WIDTH-1:0]    rd0, rd1, wr_val;
    logic [DATA_WIDTH+VW-1:0] ext_out;
    logic                     take_i;
    logic                     a_we, b_we;
    logic [AW-1:0]            a_addr, b_addr;
    logic [DATA_WIDTH-1:0]    a_data;

    function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
        logic [AW-1:0] a;
        a = (p < PW'(TOTAL)) ? p[AW-1:0] : '0;
        return a;
    endfunction

    // input values fitted to the word width
    assign ext_a  = {{DATA_WIDTH{1'b0}}, i_s_tdata[VW-1:0]};
    assign ext_b  = {{DATA_WIDTH{1'b0}}, i_s_tdata[2*VW-1:VW]};
    assign in_a_w = ext_a[DATA_WIDTH-1:0];
    assign in_b_w = ext_b[DATA_WIDTH-1:0];

    // positions and run bounds
    assign pos_a     = PW'(r_cnt);
    assign pos_b     = PW'(r_cnt) + PW'(RUN_LENGTH);
    assign two_w     = r_width << 1;
    assign left_near = r_left + r_width;
    assign left_far  = r_left + two_w;

    // read addresses and source selection
    assign addr0  = i_cmd.emit_rd ? to_addr(r_k) : to_addr(r_i);
    assign addr1  = to_addr(r_j);
    assign rd0    = r_src ? r_rd_b0 : r_rd_a0;
    assign rd1    = r_src ? r_rd_b1 : r_rd_a1;
    assign take_i = (r_i < r_mid) && ((r_j >= r_end) || (rd0 <= rd1));
    assign wr_val = take_i ? rd0 : rd1;

    // write port of buffer a
    always_comb begin
        a_we   = 1'b0;
        a_addr = to_addr(r_m);
        a_data = wr_val;
        if (i_cmd.wr_a_in) begin
            a_we   = (pos_a < PW'(TOTAL));
            a_addr = to_addr(pos_a);
            a_data = in_a_w;
        end else if (i_cmd.wr_b_in) begin
            a_we   = (pos_b < PW'(TOTAL));
            a_addr = to_addr(pos_b);
            a_data = r_in_b;
        end else if (i_cmd.merge_wr) begin
            a_we = r_src;
        end else if (i_cmd.emit_ld) begin
            a_we   = r_src;
            a_addr = to_addr(r_k);
            a_data = rd0;
        end
    end

    // write port of buffer b
    assign b_we   = i_cmd.merge_wr && !r_src;
    assign b_addr = to_addr(r_m);

    // buffer a
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[a_addr] <= a_data;
        end
        r_rd_a0 <= mem_a[addr0];
        r_rd_a1 <= mem_a[addr1];
    end

    // buffer b
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[b_addr] <= wr_val;
        end
        r_rd_b0 <= mem_b[addr0];
        r_rd_b1 <= mem_b[addr1];
    end

    // held second value of an item
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a_in) begin
            r_in_b <= in_b_w;
        end
    end

    // load count, run width, buffer select, emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_width <= '0;
            r_src   <= 1'b0;
            r_left  <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.wr_b_in) begin
                r_cnt <= o_status.load_last ? '0 : r_cnt + CW'(1);
            end
            if (i_cmd.batch_init) begin
                r_width <= PW'(RUN_LENGTH);
                r_src   <= 1'b0;
                r_left  <= '0;
                r_k     <= '0;
            end else if (i_cmd.pass_next) begin
                r_width <= two_w;
                r_src   <= ~r_src;
                r_left  <= '0;
            end else if (i_cmd.seg_next) begin
                r_left <= left_far;
            end
            if (i_cmd.emit_ld) begin
                r_k <= r_k + PW'(1);
            end
        end
    end

    // merge pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_init) begin
            r_i   <= r_left;
            r_m   <= r_left;
            r_mid <= (left_near < PW'(TOTAL)) ? left_near : PW'(TOTAL);
            r_j   <= (left_near < PW'(TOTAL)) ? left_near : PW'(TOTAL);
            r_end <= (left_far < PW'(TOTAL)) ? left_far : PW'(TOTAL);
        end else if (i_cmd.merge_wr) begin
            r_m <= r_m + PW'(1);
            if (take_i) begin
                r_i <= r_i + PW'(1);
            end else begin
                r_j <= r_j + PW'(1);
            end
        end
    end

    // output register
    assign ext_out = {{VW{1'b0}}, rd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out_value <= ext_out[VW-1:0];
            r_out_last  <= (r_k == PW'(TOTAL - 1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tlast  = r_out_last;

    // status to the controller
    assign o_status.load_last  = (r_cnt == CW'(RUN_LENGTH - 1));
    assign o_status.run_done   = (r_i >= r_mid) && (r_j >= r_end);
    assign o_status.seg_last   = (left_far >= PW'(TOTAL));
    assign o_status.merge_done = (r_width >= PW'(TOTAL));
    assign o_status.emit_last  = (r_k == PW'(TOTAL - 1));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

endmodule

@@ design/merge_sort_stage_core.sv @@
// top level of the merge sort stage: controller plus datapath
// each item stores value_a in S_LOAD and value_b in S_LOAD_B; after a batch's last item
// each merge pass starts in S_PASS, sets up each run pair in S_SEG, merges each element
// with a buffer read in S_RD and a write in S_WR, closes the pair in S_RD, and a last
// S_PASS finishes merging; each result is read in S_EMIT_RD, waiting while the output is
// full, and loaded in S_EMIT_LD. Input is taken only in S_LOAD; batches do not overlap.
// reset: synchronous active low, clears the controller, load count and output valid.
module merge_sort_stage_core #(
    parameter int RUN_LENGTH = 8,
    parameter int TOTAL      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mss_pkg::S_TDATA_W-1:0]  i_s_tdata,   // value_a [31:0], value_b [63:32]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mss_pkg::M_TDATA_W-1:0]  o_m_tdata,   // value [31:0]
    output logic                           o_m_tlast
);

    mss_pkg::t_mss_cmd    cmd;
    mss_pkg::t_mss_status status;

    // sequencing
    mss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // storage and merge logic
    mss_datapath #(
        .RUN_LENGTH (RUN_LENGTH),
        .TOTAL      (TOTAL),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ dv/merge_sort_stage_core_tb.sv @@
// self-checking testbench for merge_sort_stage_core: directed batches, then random batches
module merge_sort_stage_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LEN     = 8;
    localparam int TOTAL_WORDS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASE_BATCHES = 18;

    // one expected output item
    typedef struct packed {
        logic [mss_pkg::VALUE_W-1:0] value;
        logic                        last;
    } t_sorted_word;

    // one directed input item; typed rows carry the batch result as two constant halves
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        logic [31:0] lo_v;
        logic [31:0] hi_v;
    } t_pair_row;

    // shapes of random batches
    typedef enum int {
        KIND_SORTED_WIDE,
        KIND_SORTED_TIES,
        KIND_SORTED_EDGES,
        KIND_UNSORTED
    } t_batch_kind;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [mss_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tready = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [mss_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    int unsigned s_idle_pct = 0;
    int unsigned m_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // predictor state
    logic [31:0]  sort_words [TOTAL_WORDS];
    logic [31:0]  scratch_words [TOTAL_WORDS];
    int unsigned  fill_count = 0;
    t_sorted_word sorted_q [$];

    t_pair_row dir_rows [24] = '{
        // constant halves, low half all zeros and high half all ones
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        // constant halves swapped, the right run must come out first
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        // unsorted halves with ties across the runs
        '{32'h0000_0009, 32'h0000_0006, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0005, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{32'hFFFF_FFFE, 32'h0000_0009, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0005, 32'h0000_0005, 1'b0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h0000_0009, 1'b0, 32'h0, 32'h0}
    };

    merge_sort_stage_core #(
        .RUN_LENGTH (RUN_LEN),
        .TOTAL      (TOTAL_WORDS),
        .DATA_WIDTH (32)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // value_a [31:0], value_b [63:32]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // value [31:0]
        .o_m_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("merge_sort_stage_core_tb: done, errors");
            $finish;
        end
    end

    // one stable merge pass over runs of the given width
    function automatic void merge_runs(int width);
        int left, mid, stop, i, j, m;
        for (left = 0; left + width < TOTAL_WORDS; left += 2 * width) begin
            mid  = left + width;
            stop = (mid + width > TOTAL_WORDS) ? TOTAL_WORDS : mid + width;
            i = left;
            j = mid;
            m = left;
            while (i < mid && j < stop) begin
                if (sort_words[i] <= sort_words[j]) begin
                    scratch_words[m] = sort_words[i];
                    i++;
                end else begin
                    scratch_words[m] = sort_words[j];
                    j++;
                end
                m++;
            end
            while (i < mid) begin
                scratch_words[m] = sort_words[i];
                i++;
                m++;
            end
            while (j < stop) begin
                scratch_words[m] = sort_words[j];
                j++;
                m++;
            end
            for (m = left; m < stop; m++)
                sort_words[m] = scratch_words[m];
        end
    endfunction

    // store one accepted item; on the batch's last item merge and queue the sorted words
    function automatic void absorb_pair(logic [31:0] a, logic [31:0] b, t_pair_row row);
        int width, n;
        t_sorted_word word;
        if (fill_count < TOTAL_WORDS)
            sort_words[fill_count] = a;
        if (fill_count + RUN_LEN < TOTAL_WORDS)
            sort_words[fill_count + RUN_LEN] = b;
        fill_count++;
        if (fill_count < RUN_LEN)
            return;
        fill_count = 0;
        for (width = RUN_LEN; width < TOTAL_WORDS; width *= 2)
            merge_runs(width);
        for (n = 0; n < TOTAL_WORDS; n++) begin
            if (row.typed)
                word.value = (n < RUN_LEN) ? row.lo_v : row.hi_v;
            else
                word.value = sort_words[n];
            word.last = (n == TOTAL_WORDS - 1);
            sorted_q.push_back(word);
        end
    endfunction

    // drive one item and wait for its handshake
    task automatic send_pair(logic [31:0] a, logic [31:0] b, t_pair_row row);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        absorb_pair(a, b, row);
    endtask

    function automatic logic [31:0] pick_value(t_batch_kind kind);
        case (kind)
            KIND_SORTED_TIES:  pick_value = $urandom_range(0, 5);
            KIND_SORTED_EDGES: begin
                case ($urandom_range(0, 5))
                    0:       pick_value = 32'h0000_0000;
                    1:       pick_value = 32'hFFFF_FFFF;
                    2:       pick_value = 32'h7FFF_FFFF;
                    3:       pick_value = 32'h8000_0000;
                    4:       pick_value = 32'h0000_0001;
                    default: pick_value = $urandom;
                endcase
            end
            default:           pick_value = $urandom;
        endcase
    endfunction

    // one random batch; most are sorted halves, the rest arrive unsorted
    task automatic send_batch();
        logic [31:0] a_q [$];
        logic [31:0] b_q [$];
        t_batch_kind kind;
        t_pair_row   plain_row;
        int          n, roll;
        plain_row = '0;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            kind = KIND_SORTED_WIDE;
        else if (roll < 65)
            kind = KIND_SORTED_TIES;
        else if (roll < 85)
            kind = KIND_SORTED_EDGES;
        else
            kind = KIND_UNSORTED;
        for (n = 0; n < RUN_LEN; n++) begin
            a_q.push_back(pick_value(kind));
            b_q.push_back(pick_value(kind));
        end
        if (kind != KIND_UNSORTED) begin
            a_q.sort();
            b_q.sort();
        end
        for (n = 0; n < RUN_LEN; n++)
            send_pair(a_q[n], b_q[n], plain_row);
    endtask

    // compare one output item with the oldest expectation
    task automatic check_word(logic [31:0] value, logic last);
        t_sorted_word want;
        if (sorted_q.size() == 0) begin
            $error("unexpected item: value %h last %b", value, last);
            error_count++;
            return;
        end
        want = sorted_q.pop_front();
        if (value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, value);
            error_count++;
        end
        if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            error_count++;
        end
    endtask

    // receiver: random stalls and checking at the handshake
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
        if (i_rst_n && m_tvalid && m_tready)
            check_word(m_tdata, m_tlast);
    end

    // stimulus
    initial begin
        int n, phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (n = 0; n < 24; n++)
            send_pair(dir_rows[n].a, dir_rows[n].b, dir_rows[n]);

        // random batches: slow receiver, then slow sender, then full rate
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin s_idle_pct = 7;  m_stall_pct = 76; end
                1:       begin s_idle_pct = 76; m_stall_pct = 7;  end
                default: begin s_idle_pct = 0;  m_stall_pct = 0;  end
            endcase
            for (n = 0; n < PHASE_BATCHES; n++)
                send_batch();
        end
        s_tvalid <= 1'b0;

        // drain
        while (sorted_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("merge_sort_stage_core_tb: done, clean");
        else
            $display("merge_sort_stage_core_tb: done, errors");
        $finish;
    end

endmodule
